### rtl/core/swer_pkg.sv
package swer_pkg;

    // fixed field widths
    localparam int RATE_BITS     = 48;
    localparam int FRAC_BITS     = 16;
    localparam int TPS_BITS      = 32;
    localparam int WSIZE_BITS    = 7;
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    // defaults for the top level parameters
    localparam int DEF_WINDOW_DEPTH = 64;
    localparam int DEF_STAMP_BITS   = 48;

    // smallest window that yields a rate
    localparam int MIN_FOR_RATE = 2;

    // register reset values
    localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = 7'd16;
    localparam logic [TPS_BITS-1:0]   TPS_RESET   = 32'd1000000;

    // register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_WIN_LEN          = 4'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_TICKS_PER_SECOND = 4'd1;

    // request codes
    localparam logic REQ_EVENT = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SPAN,
        ST_MUL,
        ST_DIVGO,
        ST_DIV,
        ST_DONE
    } swer_state_t;

    typedef struct packed {
        logic done;
        logic overflow;
    } swer_div_stat_t;

endpackage

### rtl/core/swer_ifs.sv
interface swer_req_if #(
    parameter int STAMP_BITS = 48
);
    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [STAMP_BITS-1:0] timestamp;

    modport source (output valid, output req_type, output timestamp, input ready);
    modport sink   (input valid, input req_type, input timestamp, output ready);
endinterface

interface swer_res_if #(
    parameter int COUNT_BITS = 7
);
    import swer_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [RATE_BITS-1:0]  rate_q16;
    logic                  rate_valid;
    logic                  rate_saturated;
    logic [COUNT_BITS-1:0] held_count;

    modport source (output valid, output rate_q16, output rate_valid,
                    output rate_saturated, output held_count, input ready);
    modport sink   (input valid, input rate_q16, input rate_valid,
                    input rate_saturated, input held_count, output ready);
endinterface

interface swer_cfg_if;
    import swer_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_ADDR_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/swer_div.sv
module swer_div #(
    parameter int NUM_BITS = 55,
    parameter int DEN_BITS = 48
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [NUM_BITS-1:0]            dividend,
    input  logic [DEN_BITS-1:0]            divisor,
    output logic [swer_pkg::RATE_BITS-1:0] rate,
    output swer_pkg::swer_div_stat_t       stat
);
    import swer_pkg::*;

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [NUM_BITS-1:0] num_reg, num_next;
    logic [NUM_BITS-1:0] quo_reg, quo_next;
    logic [DEN_BITS-1:0] den_reg, den_next;
    logic [DEN_BITS-1:0] rem_reg, rem_next;
    logic [DEN_BITS:0]   trial;
    logic [DEN_BITS:0]   diff;
    logic                take;
    logic                ovf;

    // one restoring step per cycle, msb first
    always_comb
    begin
        trial     = {rem_reg, num_reg[NUM_BITS-1]};
        diff      = trial - {1'b0, den_reg};
        take      = (trial >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(NUM_BITS);
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[NUM_BITS-2:0], 1'b0};
            quo_next = {quo_reg[NUM_BITS-2:0], take};
            rem_next = take ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    // quotient bits above the rate field mean overflow
    assign ovf           = |quo_reg[NUM_BITS-1:RATE_BITS];
    assign rate          = ovf ? {RATE_BITS{1'b1}} : quo_reg[RATE_BITS-1:0];
    assign stat.done     = done_reg;
    assign stat.overflow = ovf;

endmodule

### rtl/core/sliding_window_event_rate.sv
// sliding window event rate meter. each event transfer on req pushes its
// timestamp into a ring of the last win_len stamps (the oldest drops once
// the window is full); a clear transfer empties the window. every request
// gives exactly one result transfer on res: held_count, and with two or more
// stamps held the rate (held_count-1)*ticks_per_second/(newest-oldest) as
// unsigned q.16, span taken modulo 2^STAMP_BITS. a zero span or a quotient
// beyond 48 bits gives all ones with rate_saturated set. one request is in
// work at a time; a finished result waits in the output register while the
// next request is taken. a clear, or an event leaving fewer than two stamps,
// goes straight to the result; a rate is worked out by a shift-add
// multiplier over the bits of held_count-1, then a restoring divider giving
// one quotient bit per cycle over the NUM_BITS-bit numerator, which sets
// the pace; a zero span skips the divider. the ring is a single-port-write,
// single-read memory with a registered read; slots are read only after
// being written, so it needs no clearing after reset. configuration writes
// are taken every cycle and are meant only while no request is in work.
module sliding_window_event_rate #(
    parameter int WINDOW_DEPTH = swer_pkg::DEF_WINDOW_DEPTH,
    parameter int STAMP_BITS   = swer_pkg::DEF_STAMP_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    swer_cfg_if.sink     cfg,
    swer_req_if.sink     req,
    swer_res_if.source   res
);
    import swer_pkg::*;

    localparam int IDX_BITS   = $clog2(WINDOW_DEPTH);
    localparam int COUNT_BITS = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_BITS   = COUNT_BITS + 1;
    localparam int PROD_BITS  = COUNT_BITS + TPS_BITS;
    localparam int NUM_BITS   = PROD_BITS + FRAC_BITS;
    localparam int MCNT_BITS  = $clog2(COUNT_BITS + 1);

    // configuration registers
    logic [WSIZE_BITS-1:0] win_len_reg;
    logic [TPS_BITS-1:0]   tps_reg;

    // window state
    swer_state_t           state_reg, state_next;
    logic [IDX_BITS-1:0]   oldest_reg, oldest_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    // datapath
    logic [STAMP_BITS-1:0] newest_reg, newest_next;
    logic [STAMP_BITS-1:0] rd_data_reg;
    logic [STAMP_BITS-1:0] span_reg, span_next;
    logic [COUNT_BITS-1:0] mul_m_reg, mul_m_next;
    logic [PROD_BITS-1:0]  mul_acc_reg, mul_acc_next;
    logic [MCNT_BITS-1:0]  mul_cnt_reg, mul_cnt_next;

    // pending result and output register
    logic [RATE_BITS-1:0]  pend_rate_reg, pend_rate_next;
    logic                  pend_rv_reg, pend_rv_next;
    logic                  pend_sat_reg, pend_sat_next;
    logic                  out_valid_reg, out_valid_next;
    logic [RATE_BITS-1:0]  out_rate_reg, out_rate_next;
    logic                  out_rv_reg, out_rv_next;
    logic                  out_sat_reg, out_sat_next;
    logic [COUNT_BITS-1:0] out_cnt_reg, out_cnt_next;

    // ring memory
    logic [STAMP_BITS-1:0] ring [WINDOW_DEPTH];
    logic                  ring_we;
    logic                  ring_re;
    logic [IDX_BITS-1:0]   slot;

    // push arithmetic
    logic                  in_xfer;
    logic [COUNT_BITS-1:0] eff_window;
    logic                  drop;
    logic [IDX_BITS-1:0]   oldest_inc;
    logic [IDX_BITS-1:0]   oldest_drop;
    logic [COUNT_BITS-1:0] count_drop;
    logic [COUNT_BITS-1:0] count_push;
    logic [SUM_BITS-1:0]   slot_raw;
    logic [SUM_BITS-1:0]   slot_sum;

    // divider
    logic                  div_start;
    logic [RATE_BITS-1:0]  div_rate;
    swer_div_stat_t        div_stat;

    // ------------------------------------------------------------------
    // configuration port, always ready; unknown indexes are dropped
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg <= WSIZE_RESET;
            tps_reg     <= TPS_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_WIN_LEN:          win_len_reg <= cfg.data[WSIZE_BITS-1:0];
                CFG_TICKS_PER_SECOND: tps_reg     <= cfg.data[TPS_BITS-1:0];
                default:              ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // push bookkeeping for an event transfer
    // ------------------------------------------------------------------
    assign req.ready = (state_reg == ST_IDLE);
    assign in_xfer   = req.valid && req.ready;

    always_comb
    begin
        // zero acts as one, anything past the ring depth as the depth
        if (win_len_reg == '0)
            eff_window = COUNT_BITS'(1);
        else if (int'(win_len_reg) > WINDOW_DEPTH)
            eff_window = COUNT_BITS'(WINDOW_DEPTH);
        else
            eff_window = COUNT_BITS'(win_len_reg);

        oldest_inc  = (oldest_reg == IDX_BITS'(WINDOW_DEPTH - 1)) ? '0
                                                                 : oldest_reg + IDX_BITS'(1);
        // a full (or over-full after a shrink) window drops its oldest stamp
        drop        = (count_reg >= eff_window) && (count_reg != '0);
        oldest_drop = drop ? oldest_inc : oldest_reg;
        count_drop  = drop ? count_reg - COUNT_BITS'(1) : count_reg;
        count_push  = count_drop + COUNT_BITS'(1);

        // new slot sits count_drop past the oldest, modulo the depth
        slot_raw = SUM_BITS'(oldest_drop) + SUM_BITS'(count_drop);
        slot_sum = (slot_raw >= SUM_BITS'(WINDOW_DEPTH)) ? slot_raw - SUM_BITS'(WINDOW_DEPTH)
                                                         : slot_raw;
        slot     = slot_sum[IDX_BITS-1:0];
    end

    assign ring_we = in_xfer && (req.req_type == REQ_EVENT);
    assign ring_re = (state_reg == ST_READ);

    // the newest stamp is kept in newest_reg, so only the oldest is read back
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring[slot] <= req.timestamp;
        if (ring_re)
            rd_data_reg <= ring[oldest_reg];
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        oldest_next    = oldest_reg;
        count_next     = count_reg;
        newest_next    = newest_reg;
        span_next      = span_reg;
        mul_m_next     = mul_m_reg;
        mul_acc_next   = mul_acc_reg;
        mul_cnt_next   = mul_cnt_reg;
        pend_rate_next = pend_rate_reg;
        pend_rv_next   = pend_rv_reg;
        pend_sat_next  = pend_sat_reg;
        out_valid_next = out_valid_reg;
        out_rate_next  = out_rate_reg;
        out_rv_next    = out_rv_reg;
        out_sat_next   = out_sat_reg;
        out_cnt_next   = out_cnt_reg;
        div_start      = 1'b0;

        // result taken downstream
        if (out_valid_reg && res.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    pend_rate_next = '0;
                    pend_rv_next   = 1'b0;
                    pend_sat_next  = 1'b0;
                    if (req.req_type == REQ_CLEAR)
                    begin
                        oldest_next = '0;
                        count_next  = '0;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        oldest_next = oldest_drop;
                        count_next  = count_push;
                        newest_next = req.timestamp;
                        if (count_push < COUNT_BITS'(MIN_FOR_RATE))
                            state_next = ST_DONE;
                        else
                            state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_SPAN;
            end
            ST_SPAN:
            begin
                // span wraps with the timestamp counter
                span_next    = newest_reg - rd_data_reg;
                mul_m_next   = count_reg - COUNT_BITS'(1);
                mul_acc_next = '0;
                mul_cnt_next = MCNT_BITS'(COUNT_BITS);
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                // shift-add, msb of the event count first
                mul_acc_next = {mul_acc_reg[PROD_BITS-2:0], 1'b0}
                             + (mul_m_reg[COUNT_BITS-1] ? PROD_BITS'(tps_reg) : '0);
                mul_m_next   = mul_m_reg << 1;
                mul_cnt_next = mul_cnt_reg - MCNT_BITS'(1);
                if (mul_cnt_reg == MCNT_BITS'(1))
                begin
                    if (span_reg == '0)
                    begin
                        pend_rate_next = {RATE_BITS{1'b1}};
                        pend_rv_next   = 1'b1;
                        pend_sat_next  = 1'b1;
                        state_next     = ST_DONE;
                    end
                    else
                        state_next = ST_DIVGO;
                end
            end
            ST_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                begin
                    pend_rate_next = div_rate;
                    pend_rv_next   = 1'b1;
                    pend_sat_next  = div_stat.overflow;
                    state_next     = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_rate_next  = pend_rate_reg;
                    out_rv_next    = pend_rv_reg;
                    out_sat_next   = pend_sat_reg;
                    out_cnt_next   = count_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            oldest_reg    <= '0;
            count_reg     <= '0;
            mul_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            mul_cnt_reg   <= mul_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        newest_reg    <= newest_next;
        span_reg      <= span_next;
        mul_m_reg     <= mul_m_next;
        mul_acc_reg   <= mul_acc_next;
        pend_rate_reg <= pend_rate_next;
        pend_rv_reg   <= pend_rv_next;
        pend_sat_reg  <= pend_sat_next;
        out_rate_reg  <= out_rate_next;
        out_rv_reg    <= out_rv_next;
        out_sat_reg   <= out_sat_next;
        out_cnt_reg   <= out_cnt_next;
    end

    // ------------------------------------------------------------------
    // quotient unit: numerator is the product scaled by 2^16
    // ------------------------------------------------------------------
    swer_div #(
        .NUM_BITS (NUM_BITS),
        .DEN_BITS (STAMP_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({mul_acc_reg, {FRAC_BITS{1'b0}}}),
        .divisor  (span_reg),
        .rate     (div_rate),
        .stat     (div_stat)
    );

    // result channel
    assign res.valid          = out_valid_reg;
    assign res.rate_q16       = out_rate_reg;
    assign res.rate_valid     = out_rv_reg;
    assign res.rate_saturated = out_sat_reg;
    assign res.held_count     = out_cnt_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_BITS'(WINDOW_DEPTH))
        else $error("window holds more stamps than the ring depth");

    a_oldest_bound: assert property (@(posedge clk) disable iff (!rst_n)
        oldest_reg <= IDX_BITS'(WINDOW_DEPTH - 1))
        else $error("oldest index outside the ring");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && (req.req_type == REQ_CLEAR) |=> count_reg == '0)
        else $error("clear transfer left stamps in the window");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == ST_DIV)
        else $error("quotient finished outside the divide phase");

    a_no_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_rv_reg |-> out_rate_reg == '0 && !out_sat_reg)
        else $error("rate reported without two stamps held");

    a_rate_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_rv_reg |-> out_cnt_reg >= COUNT_BITS'(MIN_FOR_RATE))
        else $error("rate valid with fewer than two stamps");

endmodule

### sim/swer_rate_checker.sv
`timescale 1ns / 1ps

module swer_rate_checker
    import swer_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    swer_cfg_if  cfg,
    swer_req_if  req,
    swer_res_if  res,
    output int   errors,
    output int   pending
);

    localparam int DEPTH = DEF_WINDOW_DEPTH;
    localparam int MAX_PRINTED = 40;
    localparam logic [RATE_BITS-1:0] RATE_ALL_ONES = '1;

    typedef struct packed {
        logic [RATE_BITS-1:0]  rate_q16;
        logic                  rate_valid;
        logic                  rate_saturated;
        logic [WSIZE_BITS-1:0] held_count;
    } rate_report_t;

    logic [DEF_STAMP_BITS-1:0] stamp_hist [DEPTH];
    int                        oldest;
    int                        held;
    logic [WSIZE_BITS-1:0]     win_size;
    logic [TPS_BITS-1:0]       tick_rate;
    rate_report_t              expected_rates [$];

    function automatic int window_limit();
        if (win_size == 0)
            return 1;
        if (int'(win_size) > DEPTH)
            return DEPTH;
        return int'(win_size);
    endfunction

    // advances the window by one request and returns the rate it reports
    function automatic rate_report_t next_rate(input logic kind,
                                               input logic [DEF_STAMP_BITS-1:0] stamp);
        rate_report_t              r;
        logic [DEF_STAMP_BITS-1:0] span;
        logic [63:0]               num;
        logic [63:0]               quo;
        r = '0;
        if (kind == REQ_CLEAR)
        begin
            oldest = 0;
            held   = 0;
        end
        else
        begin
            if (held >= window_limit())
            begin
                oldest = (oldest + 1) % DEPTH;
                held--;
            end
            stamp_hist[(oldest + held) % DEPTH] = stamp;
            held++;
        end
        if (held >= MIN_FOR_RATE)
        begin
            span = stamp_hist[(oldest + held - 1) % DEPTH] - stamp_hist[oldest];
            num  = (64'(held - 1) * 64'(tick_rate)) << FRAC_BITS;
            r.rate_valid = 1'b1;
            if (span == 0)
            begin
                r.rate_q16       = RATE_ALL_ONES;
                r.rate_saturated = 1'b1;
            end
            else
            begin
                quo = num / 64'(span);
                if (quo > 64'(RATE_ALL_ONES))
                begin
                    r.rate_q16       = RATE_ALL_ONES;
                    r.rate_saturated = 1'b1;
                end
                else
                    r.rate_q16 = quo[RATE_BITS-1:0];
            end
        end
        r.held_count = WSIZE_BITS'(held);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (errors < MAX_PRINTED)
            $display("%0t: rate result %s: got %0h, expected %0h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rate_report_t want;
        if (!rst_n)
        begin
            oldest    = 0;
            held      = 0;
            win_size  = WSIZE_RESET;
            tick_rate = TPS_RESET;
            expected_rates.delete();
            errors    = 0;
            pending   = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_WIN_LEN)
                    win_size = cfg.data[WSIZE_BITS-1:0];
                else if (cfg.index == CFG_TICKS_PER_SECOND)
                    tick_rate = cfg.data[TPS_BITS-1:0];
            end
            if (req.valid && req.ready)
                expected_rates.push_back(next_rate(req.req_type, req.timestamp));
            if (res.valid && res.ready)
            begin
                if (expected_rates.size() == 0)
                    report_mismatch("with none outstanding", 64'(res.rate_q16), '0);
                else
                begin
                    want = expected_rates.pop_front();
                    if (res.rate_q16 !== want.rate_q16)
                        report_mismatch("rate_q16", 64'(res.rate_q16), 64'(want.rate_q16));
                    if (res.rate_valid !== want.rate_valid)
                        report_mismatch("rate_valid", 64'(res.rate_valid),
                                        64'(want.rate_valid));
                    if (res.rate_saturated !== want.rate_saturated)
                        report_mismatch("rate_saturated", 64'(res.rate_saturated),
                                        64'(want.rate_saturated));
                    if (res.held_count !== want.held_count)
                        report_mismatch("held_count", 64'(res.held_count),
                                        64'(want.held_count));
                end
            end
            pending = expected_rates.size();
        end
    end

endmodule

### sim/sliding_window_event_rate_test.sv
`timescale 1ns / 1ps

module sliding_window_event_rate_test;
    import swer_pkg::*;

    localparam int STAMP_W       = DEF_STAMP_BITS;
    localparam int RANDOM_ITEMS  = 950;
    localparam int SETTLE_CYCLES = 80;

    // indexes past the two real registers, written to check they are ignored
    localparam logic [CFG_ADDR_BITS-1:0] CFG_FIRST_SPARE = CFG_TICKS_PER_SECOND + 1'b1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_LAST_SPARE  = '1;

    localparam logic [TPS_BITS-1:0]   TPS_MAX   = '1;
    localparam logic [WSIZE_BITS-1:0] WSIZE_MAX = '1;
    localparam logic [STAMP_W-1:0]    STAMP_MAX = '1;

    logic               clk;
    logic               rst_n;
    logic               calm;        // phase with no idling on either side
    int                 errors;
    int                 pending;
    int                 items_sent;
    logic [STAMP_W-1:0] clock_now;   // running timestamp of the event stream

    swer_cfg_if                         cfg_bus();
    swer_req_if #(.STAMP_BITS(STAMP_W)) req_bus();
    swer_res_if                         res_bus();

    sliding_window_event_rate u_top (
        .clk,
        .rst_n,
        .cfg (cfg_bus),
        .req (req_bus),
        .res (res_bus)
    );

    swer_rate_checker u_checker (
        .clk,
        .rst_n,
        .cfg     (cfg_bus),
        .req     (req_bus),
        .res     (res_bus),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin : watchdog
        #10_000_000;
        $display("FAIL");
        $finish;
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 15);
        return $urandom_range(20, 70);
    endfunction

    function automatic logic [STAMP_W-1:0] rand_stamp();
        return STAMP_W'({$urandom, $urandom});
    endfunction

    // step between event stamps: repeats, tight bursts, sparse events, wild jumps
    function automatic logic [STAMP_W-1:0] next_delta();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2, 3: return STAMP_W'($urandom_range(1, 16));
            4, 5, 6: return STAMP_W'($urandom_range(1, 1 << 20));
            7, 8:    return STAMP_W'($urandom);
            default: return rand_stamp();
        endcase
    endfunction

    // result side: ready drops in bursts of random length
    initial
    begin : result_pacing
        int   hold;
        logic stall;
        res_bus.ready = 1'b0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else
            begin
                stall = !calm && ($urandom_range(0, 3) == 0);
                res_bus.ready <= !stall;
                hold = stall ? pick_gap() : $urandom_range(0, 8);
            end
        end
    end

    // one register write; valid drops for a cycle after the transfer
    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        logic took;
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do
        begin
            @(negedge clk);
            took = cfg_bus.ready;
            @(posedge clk);
        end
        while (!took);
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // window size goes in the low bits, the rest of the word is junk
    task automatic set_config(input logic [WSIZE_BITS-1:0] ws, input logic [TPS_BITS-1:0] tps);
        logic [CFG_DATA_BITS-1:0] word;
        word = $urandom;
        word[WSIZE_BITS-1:0] = ws;
        write_reg(CFG_WIN_LEN, word);
        write_reg(CFG_TICKS_PER_SECOND, CFG_DATA_BITS'(tps));
    endtask

    // one request transfer, with an optional gap in front; valid stays high
    // afterwards so back-to-back requests leave no gap in valid
    task automatic send_item(input logic kind, input logic [STAMP_W-1:0] stamp);
        int   gap;
        logic took;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.req_type  <= kind;
        req_bus.timestamp <= stamp;
        do
        begin
            @(negedge clk);
            took = req_bus.ready;
            @(posedge clk);
        end
        while (!took);
        items_sent++;
    endtask

    // stop sending and wait for every outstanding result
    task automatic settle_phase();
        req_bus.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    // random settings, then a run of mostly ordered events with some noise
    task automatic random_phase();
        int                    n;
        int                    roll;
        logic [WSIZE_BITS-1:0] ws;
        logic [TPS_BITS-1:0]   tps;
        calm = ($urandom_range(0, 4) == 0);
        case ($urandom_range(0, 7))
            0:       ws = '0;
            1:       ws = WSIZE_BITS'(1);
            2:       ws = WSIZE_BITS'(2);
            3:       ws = WSIZE_BITS'(DEF_WINDOW_DEPTH);
            4:       ws = WSIZE_BITS'($urandom_range(DEF_WINDOW_DEPTH + 1, WSIZE_MAX));
            default: ws = WSIZE_BITS'($urandom_range(1, DEF_WINDOW_DEPTH));
        endcase
        case ($urandom_range(0, 15))
            0:       tps = '0;
            1, 2:    tps = TPS_BITS'(1);
            3, 4:    tps = TPS_MAX;
            5, 6:    tps = TPS_RESET;
            7:       tps = $urandom_range(2, 1000);
            default: tps = $urandom;
        endcase
        // sometimes keep the old settings, so a shrunk window meets a full ring
        if ($urandom_range(0, 3) != 0)
            set_config(ws, tps);
        if ($urandom_range(0, 5) == 0)
            write_reg(CFG_ADDR_BITS'($urandom_range(CFG_FIRST_SPARE, CFG_LAST_SPARE)),
                      $urandom);
        // start near the top of the counter now and then so spans wrap
        roll = $urandom_range(0, 7);
        if (roll == 0)
            clock_now = STAMP_MAX - STAMP_W'($urandom_range(0, 1 << 16));
        else if (roll == 1)
            clock_now = rand_stamp();
        if ($urandom_range(0, 2) == 0)
            send_item(REQ_CLEAR, rand_stamp());
        n = $urandom_range(8, 70);
        for (int i = 0; i < n && items_sent < RANDOM_ITEMS; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                send_item(REQ_CLEAR, rand_stamp());
            else if (roll < 10)
                send_item(REQ_EVENT, rand_stamp());  // stamp out of order
            else
            begin
                clock_now = clock_now + next_delta();
                send_item(REQ_EVENT, clock_now);
            end
        end
        settle_phase();
    endtask

    initial
    begin : stimulus
        cfg_bus.valid     = 1'b0;
        cfg_bus.index     = CFG_WIN_LEN;
        cfg_bus.data      = '0;
        req_bus.valid     = 1'b0;
        req_bus.req_type  = REQ_EVENT;
        req_bus.timestamp = '0;
        calm       = 1'b0;
        items_sent = 0;
        clock_now  = rand_stamp();
        rst_n      = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: window of 16, a million ticks per second
        send_item(REQ_CLEAR, STAMP_MAX);                 // clear with nothing held
        send_item(REQ_EVENT, '0);                        // lone stamp, no rate
        send_item(REQ_EVENT, '0);                        // zero span saturates
        send_item(REQ_EVENT, STAMP_MAX);                 // widest span
        send_item(REQ_EVENT, STAMP_W'(5));
        send_item(REQ_CLEAR, '0);
        send_item(REQ_EVENT, STAMP_MAX - STAMP_W'(2));
        send_item(REQ_EVENT, STAMP_W'(3));               // span wraps past zero
        settle_phase();

        // window of zero behaves as one: count never reaches two
        set_config('0, TPS_MAX);
        send_item(REQ_CLEAR, rand_stamp());
        send_item(REQ_EVENT, STAMP_W'(100));
        send_item(REQ_EVENT, STAMP_W'(200));
        settle_phase();

        // oversized window clamps to the ring depth; spare indexes do nothing
        set_config(WSIZE_MAX, TPS_MAX);
        write_reg(CFG_FIRST_SPARE, '1);
        write_reg(CFG_LAST_SPARE, '0);
        send_item(REQ_CLEAR, rand_stamp());
        send_item(REQ_EVENT, STAMP_W'(10));
        send_item(REQ_EVENT, STAMP_W'(10));
        send_item(REQ_EVENT, STAMP_W'(11));              // one tick span overflows
        settle_phase();

        // zero tick rate: rate zero unless the span is zero too
        set_config(WSIZE_BITS'(3), '0);
        send_item(REQ_EVENT, STAMP_W'(30));
        send_item(REQ_EVENT, STAMP_W'(11));              // newest equals oldest
        settle_phase();

        // window shrunk below the count: count holds at three
        set_config(WSIZE_BITS'(2), TPS_BITS'(1));
        send_item(REQ_EVENT, STAMP_W'(40));
        send_item(REQ_EVENT, STAMP_W'(50));
        settle_phase();

        // full depth at the reset tick rate
        set_config(WSIZE_BITS'(DEF_WINDOW_DEPTH), TPS_RESET);
        send_item(REQ_CLEAR, rand_stamp());
        for (int i = 1; i <= 5; i++)
            send_item(REQ_EVENT, STAMP_W'(i * 1000));
        settle_phase();

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
            random_phase();

        // let any stray result show up before the verdict
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/core/swer_pkg.sv
rtl/core/swer_ifs.sv
rtl/core/swer_div.sv
rtl/core/sliding_window_event_rate.sv
sim/swer_rate_checker.sv
sim/sliding_window_event_rate_test.sv
